// ===== hw/rtl/lsc_pkg.sv =====
package lsc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int MINOR_W = PROD_W + 1;
    localparam int PART_W  = 2 * DATA_WIDTH + 1;
    localparam int TERM_W  = 3 * DATA_WIDTH + 1;
    localparam int DET_W   = 3 * DATA_WIDTH + 3;
    localparam int REM_W   = DET_W + DATA_WIDTH + FRAC_BITS;

    localparam int N_MINOR = 7;
    localparam int N_TERM  = 12;
    localparam int N_ROW   = 4;
    localparam int N_DET   = 4;
    localparam int DET_LAT = 5;
    localparam int DIV_LAT = DATA_WIDTH + 2;

    localparam int DET_MAIN = 0;
    localparam int DET_X    = 1;
    localparam int DET_Y    = 2;
    localparam int DET_Z    = 3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [MINOR_W-1:0]    minor_t;
    typedef logic signed [PART_W-1:0]     part_t;
    typedef logic signed [TERM_W-1:0]     term_t;
    typedef logic signed [DET_W-1:0]      det_t;

    typedef enum logic [1:0] {
        STAT_UNIQUE   = 2'd0,
        STAT_INFINITE = 2'd1,
        STAT_INCONS   = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        logic hom;
    } det_ctl_t;

    typedef struct packed {
        logic    valid;
        logic    hom;
        status_t status;
    } side_t;

endpackage

// ===== hw/rtl/lsc_det.sv =====
module lsc_det
    import lsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     valid_in,
    input  data_t    row1 [N_ROW],
    input  data_t    row2 [N_ROW],
    input  data_t    row3 [N_ROW],
    output det_ctl_t ctl_out,
    output det_t     det_out [N_DET]
);

    // Column codes: 0 x, 1 y, 2 z, 3 right-hand side.
    // Minors in order: bc, ac, ab, dc, db, ad, bd.
    localparam int MIN_U [N_MINOR] = '{1, 0, 0, 3, 3, 0, 1};
    localparam int MIN_V [N_MINOR] = '{2, 2, 1, 2, 1, 3, 3};
    localparam int TERM_COEF  [N_TERM] = '{0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3};
    localparam int TERM_MINOR [N_TERM] = '{0, 1, 2, 0, 3, 4, 3, 1, 5, 6, 5, 2};

    prod_t    pp_reg    [N_MINOR];
    prod_t    pn_reg    [N_MINOR];
    data_t    r1a_reg   [N_ROW];
    minor_t   minor_reg [N_MINOR];
    data_t    r1b_reg   [N_ROW];
    part_t    pl_reg    [N_TERM];
    part_t    ph_reg    [N_TERM];
    term_t    term_reg  [N_TERM];
    det_t     sum_reg   [N_DET];
    det_ctl_t ctl_reg   [DET_LAT];
    det_ctl_t ctl_next;

    assign ctl_next.valid = valid_in;
    assign ctl_next.hom   = (row1[3] == '0) && (row2[3] == '0) && (row3[3] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DET_LAT; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s < DET_LAT; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_MINOR; k++)
            begin
                pp_reg[k]    <= row2[MIN_U[k]] * row3[MIN_V[k]];
                pn_reg[k]    <= row3[MIN_U[k]] * row2[MIN_V[k]];
                minor_reg[k] <= MINOR_W'(pp_reg[k]) - MINOR_W'(pn_reg[k]);
            end
            for (int r = 0; r < N_ROW; r++)
            begin
                r1a_reg[r] <= row1[r];
                r1b_reg[r] <= r1a_reg[r];
            end
            for (int t = 0; t < N_TERM; t++)
            begin
                pl_reg[t] <= r1b_reg[TERM_COEF[t]]
                           * $signed({1'b0, minor_reg[TERM_MINOR[t]][DATA_WIDTH-1:0]});
                ph_reg[t] <= r1b_reg[TERM_COEF[t]]
                           * $signed(minor_reg[TERM_MINOR[t]][MINOR_W-1:DATA_WIDTH]);
                term_reg[t] <= (TERM_W'(ph_reg[t]) <<< DATA_WIDTH) + TERM_W'(pl_reg[t]);
            end
            for (int d = 0; d < N_DET; d++)
            begin
                sum_reg[d] <= DET_W'(term_reg[3*d]) - DET_W'(term_reg[3*d+1])
                            + DET_W'(term_reg[3*d+2]);
            end
        end
    end

    assign ctl_out = ctl_reg[DET_LAT-1];
    assign det_out = sum_reg;

endmodule

// ===== hw/rtl/lsc_div.sv =====
module lsc_div
    import lsc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  det_t  num,
    input  det_t  den,
    output data_t quot,
    output logic  ovf
);

    localparam logic [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [REM_W-1:0]      rem_reg  [DATA_WIDTH+1];
    logic [DET_W-1:0]      den_reg  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] q_reg    [DATA_WIDTH+1];
    logic                  neg_reg  [DATA_WIDTH+1];
    logic                  hiov_reg [DATA_WIDTH+1];
    logic [DET_W-1:0]      an;
    logic [DET_W-1:0]      ad;
    logic [REM_W-1:0]      rem_next;
    logic                  hiov_next;
    data_t                 quot_reg;
    logic                  ovf_reg;
    logic [DATA_WIDTH-1:0] qq;
    logic                  sat;
    logic [DATA_WIDTH-1:0] quot_next;

    always_comb
    begin
        an        = num[DET_W-1] ? DET_W'(-num) : DET_W'(num);
        ad        = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
        rem_next  = REM_W'(an) << FRAC_BITS;
        hiov_next = rem_next >= (REM_W'(ad) << DATA_WIDTH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next;
            den_reg[0]  <= ad;
            q_reg[0]    <= '0;
            neg_reg[0]  <= num[DET_W-1] ^ den[DET_W-1];
            hiov_reg[0] <= hiov_next;
        end
    end

    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_step
        localparam int BIT = DATA_WIDTH - 1 - k;
        logic [REM_W:0]        trial;
        logic [DATA_WIDTH-1:0] q_next;

        assign trial = {1'b0, rem_reg[k]} - ((REM_W+1)'(den_reg[k]) << BIT);

        always_comb
        begin
            q_next      = q_reg[k];
            q_next[BIT] = !trial[REM_W];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]      <= trial[REM_W] ? rem_reg[k] : trial[REM_W-1:0];
                q_reg[k+1]        <= q_next;
                den_reg[k+1]      <= den_reg[k];
                neg_reg[k+1]      <= neg_reg[k];
                hiov_reg[k+1]     <= hiov_reg[k];
            end
        end
    end

    always_comb
    begin
        qq = q_reg[DATA_WIDTH];
        if (neg_reg[DATA_WIDTH])
        begin
            sat = hiov_reg[DATA_WIDTH] || (qq[DATA_WIDTH-1] && (|qq[DATA_WIDTH-2:0]));
            quot_next = sat ? Q_MIN : DATA_WIDTH'(-qq);
        end
        else
        begin
            sat = hiov_reg[DATA_WIDTH] || qq[DATA_WIDTH-1];
            quot_next = sat ? Q_MAX : qq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= $signed(quot_next);
            ovf_reg  <= sat;
        end
    end

    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== hw/rtl/linear_solver_3x3_cramer.sv =====
// Solves one 3x3 linear system per request by Cramer's rule, in signed Q16.16.
// The input channel (in_valid, in_ready) carries the nine coefficients and the
// three right-hand constants; the output channel (out_valid, out_ready) returns
// x, y and z, a status code, a homogeneous flag and an overflow flag.
// The determinants are formed exactly in five pipeline stages, and each quotient
// then goes through a restoring divider with one quotient bit per stage.
// A new request is accepted in every cycle while the output is taken, so the
// throughput is one system per cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, so the output channel is empty afterward.
// When the main determinant is zero, the solution and overflow read zero and the
// status tells infinite solutions from an inconsistent system.
module linear_solver_3x3_cramer
    import lsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  data_t coef_r1_x,
    input  data_t coef_r1_y,
    input  data_t coef_r1_z,
    input  data_t rhs_r1,
    input  data_t coef_r2_x,
    input  data_t coef_r2_y,
    input  data_t coef_r2_z,
    input  data_t rhs_r2,
    input  data_t coef_r3_x,
    input  data_t coef_r3_y,
    input  data_t coef_r3_z,
    input  data_t rhs_r3,
    output logic  out_valid,
    input  logic  out_ready,
    output data_t sol_x,
    output data_t sol_y,
    output data_t sol_z,
    output logic [1:0] status,
    output logic  homogeneous,
    output logic  overflow
);

    logic     en;
    data_t    row1 [N_ROW];
    data_t    row2 [N_ROW];
    data_t    row3 [N_ROW];
    det_ctl_t det_ctl;
    det_t     dets [N_DET];
    side_t    side_reg [DIV_LAT];
    side_t    side_next;
    data_t    qx;
    data_t    qy;
    data_t    qz;
    logic     ovx;
    logic     ovy;
    logic     ovz;
    logic     unique_sol;

    assign en       = !side_reg[DIV_LAT-1].valid || out_ready;
    assign in_ready = en;

    assign row1 = '{coef_r1_x, coef_r1_y, coef_r1_z, rhs_r1};
    assign row2 = '{coef_r2_x, coef_r2_y, coef_r2_z, rhs_r2};
    assign row3 = '{coef_r3_x, coef_r3_y, coef_r3_z, rhs_r3};

    lsc_det u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (in_valid),
        .row1     (row1),
        .row2     (row2),
        .row3     (row3),
        .ctl_out  (det_ctl),
        .det_out  (dets)
    );

    lsc_div u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (dets[DET_X]),
        .den  (dets[DET_MAIN]),
        .quot (qx),
        .ovf  (ovx)
    );

    lsc_div u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (dets[DET_Y]),
        .den  (dets[DET_MAIN]),
        .quot (qy),
        .ovf  (ovy)
    );

    lsc_div u_div_z (
        .clk  (clk),
        .en   (en),
        .num  (dets[DET_Z]),
        .den  (dets[DET_MAIN]),
        .quot (qz),
        .ovf  (ovz)
    );

    always_comb
    begin
        side_next.valid = det_ctl.valid;
        side_next.hom   = det_ctl.hom;
        if (dets[DET_MAIN] != '0)
        begin
            side_next.status = STAT_UNIQUE;
        end
        else if ((dets[DET_X] == '0) && (dets[DET_Y] == '0) && (dets[DET_Z] == '0))
        begin
            side_next.status = STAT_INFINITE;
        end
        else
        begin
            side_next.status = STAT_INCONS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_LAT; s++)
            begin
                side_reg[s] <= '{valid: 1'b0, hom: 1'b0, status: STAT_UNIQUE};
            end
        end
        else if (en)
        begin
            side_reg[0] <= side_next;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign unique_sol  = side_reg[DIV_LAT-1].status == STAT_UNIQUE;
    assign out_valid   = side_reg[DIV_LAT-1].valid;
    assign status      = side_reg[DIV_LAT-1].status;
    assign homogeneous = side_reg[DIV_LAT-1].hom;
    assign sol_x       = unique_sol ? qx : '0;
    assign sol_y       = unique_sol ? qy : '0;
    assign sol_z       = unique_sol ? qz : '0;
    assign overflow    = unique_sol && (ovx || ovy || ovz);

endmodule
